@@ rtl/spjq_pkg.sv @@
// ----------------------------------------------------------------------------
// spjq_pkg
// Shared types and codes for the sorted priority job queue: request and
// response payloads, opcodes, status codes and the cell-row structures.
// ----------------------------------------------------------------------------
package spjq_pkg;

    localparam int ID_W      = 16;
    localparam int RANK_W    = 16;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int CNT_OUT_W = 5;

    // Request opcodes; the fourth code is ignored
    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 2'd0,
        OP_REMOVE_TOP = 2'd1,
        OP_DELETE_ID  = 2'd2
    } t_op;

    // Response status codes
    typedef enum logic [ST_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic [ID_W-1:0]          job_id;
        logic signed [RANK_W-1:0] job_rank;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic [ID_W-1:0]          removed_id;
        logic signed [RANK_W-1:0] removed_rank;
        logic [CNT_OUT_W-1:0]     entry_count;
    } t_rsp;

    // One job as held in a cell
    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [RANK_W-1:0] rank;
    } t_job;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic rm_top;
        logic rm_id;
        t_job job;
    } t_cell_cmd;

    // Removal token that ripples down the row
    typedef struct packed {
        logic found;
        t_job job;
    } t_chain;

endpackage

@@ rtl/spjq_stream_if.sv @@
// ----------------------------------------------------------------------------
// spjq_stream_if
// Valid/ready channel carrying one payload of a configurable packed type.
// ----------------------------------------------------------------------------
interface spjq_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/spjq_cell.sv @@
// ----------------------------------------------------------------------------
// spjq_cell
// One slot of the sorted row. Decides locally, from its own job and its two
// neighbors, whether to hold, take the new job, or shift by one place.
// ----------------------------------------------------------------------------
module spjq_cell
    import spjq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  logic      i_valid,
    input  t_job      i_prev_job,
    input  logic      i_prev_ge,
    input  t_job      i_next_job,
    input  t_chain    i_chain,
    output t_job      o_job,
    output logic      o_ge,
    output t_chain    o_chain
);

    t_job r_job;
    t_job n_job;
    logic mark;
    logic first;

    // Compare held rank against the incoming rank
    assign o_ge = i_valid && ($signed(r_job.rank) >= $signed(i_cmd.job.rank));

    // Flag a removal candidate and pass the token on
    assign mark  = i_valid && (i_cmd.rm_top || (i_cmd.rm_id && (r_job.id == i_cmd.job.id)));
    assign first = mark && !i_chain.found;

    assign o_chain.found = i_chain.found || mark;
    assign o_chain.job   = first ? r_job : i_chain.job;

    // Hold, take the new job, shift down on insert, or shift up on removal
    always_comb begin
        priority if (i_cmd.ins && !o_ge) begin
            n_job = i_prev_ge ? i_cmd.job : i_prev_job;
        end else if ((i_cmd.rm_top || i_cmd.rm_id) && o_chain.found) begin
            n_job = i_next_job;
        end else begin
            n_job = r_job;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    assign o_job = r_job;

endmodule

@@ rtl/sorted_priority_job_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_job_queue
// Holds up to CAPACITY jobs in a row of cells, sorted by descending rank with
// equal ranks in arrival order. Each request is first captured in the request
// register; then every cell of the row compares and shifts in parallel and the
// response is registered. A new request is taken only once the row update of
// the last one has run; a stalled response holds the row update back until the
// pending response is taken. Removal
// finds the first match with a token that ripples once down the row.
// ----------------------------------------------------------------------------
module sorted_priority_job_queue
    import spjq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spjq_stream_if.sink          i_req,
    spjq_stream_if.source        o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             r_busy;
    t_req             r_cmd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    logic             exec;
    logic             full;
    logic             is_ins;
    logic             is_rm_top;
    logic             is_rm_id;
    logic [31:0]      cnt_ext;
    t_cell_cmd        cell_cmd;

    logic             cell_valid [CAPACITY];
    t_job             cell_job   [CAPACITY];
    logic             cell_ge    [CAPACITY];
    t_chain           chain      [CAPACITY+1];

    // Run the row update once the response register is free
    assign exec = r_busy && (!r_out_valid || o_rsp.ready);
    assign full = (r_count == CNT_W'(CAPACITY));

    // Decode the held request
    always_comb begin
        is_ins    = 1'b0;
        is_rm_top = 1'b0;
        is_rm_id  = 1'b0;
        unique case (t_op'(r_cmd.opcode))
            OP_INSERT:     is_ins    = 1'b1;
            OP_REMOVE_TOP: is_rm_top = 1'b1;
            OP_DELETE_ID:  is_rm_id  = 1'b1;
            default: ;
        endcase
    end

    // Broadcast command to the row
    assign cell_cmd.ins      = exec && is_ins && !full;
    assign cell_cmd.rm_top   = exec && is_rm_top;
    assign cell_cmd.rm_id    = exec && is_rm_id;
    assign cell_cmd.job.id   = r_cmd.job_id;
    assign cell_cmd.job.rank = r_cmd.job_rank;

    assign chain[0] = '0;

    // Build the row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_job prev_job;
        logic prev_ge;
        t_job next_job;

        assign cell_valid[i] = (r_count > CNT_W'(i));

        if (i == 0) begin : g_head
            assign prev_job = '0;
            assign prev_ge  = 1'b1;
        end else begin : g_body
            assign prev_job = cell_job[i-1];
            assign prev_ge  = cell_ge[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign next_job = '0;
        end else begin : g_mid
            assign next_job = cell_job[i+1];
        end

        spjq_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cell_cmd),
            .i_valid    (cell_valid[i]),
            .i_prev_job (prev_job),
            .i_prev_ge  (prev_ge),
            .i_next_job (next_job),
            .i_chain    (chain[i]),
            .o_job      (cell_job[i]),
            .o_ge       (cell_ge[i]),
            .o_chain    (chain[i+1])
        );
    end

    // Next count and response
    always_comb begin
        n_count = r_count;
        if (is_ins && !full) begin
            n_count = r_count + 1'b1;
        end else if ((is_rm_top || is_rm_id) && chain[CAPACITY].found) begin
            n_count = r_count - 1'b1;
        end
    end

    assign cnt_ext = 32'(n_count);

    always_comb begin
        n_rsp.status = ST_DONE;
        if (is_ins && full) begin
            n_rsp.status = ST_FULL;
        end else if ((is_rm_top || is_rm_id) && !chain[CAPACITY].found) begin
            n_rsp.status = ST_MISS;
        end
        n_rsp.removed_id   = chain[CAPACITY].job.id;
        n_rsp.removed_rank = chain[CAPACITY].job.rank;
        n_rsp.entry_count  = cnt_ext[CNT_OUT_W-1:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_busy <= 1'b1;
            end else if (exec) begin
                r_busy <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_cmd <= i_req.payload;
        end
        if (exec) begin
            r_rsp <= n_rsp;
        end
    end

    assign i_req.ready   = !r_busy;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("job count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && is_ins && !full |=> r_count == CNT_W'($past(r_count) + 1'b1))
        else $error("insert did not grow the count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_rsp.status == ST_FULL) |-> r_count == CNT_W'(CAPACITY))
        else $error("full status while queue not full");
`endif

endmodule

@@ bench/job_queue_checker.sv @@
// ----------------------------------------------------------------------------
// job_queue_checker
// Watches the request and response channels of the sorted priority job
// queue. It keeps its own sorted copy of the held jobs, works out the
// response of every accepted request and compares each accepted response,
// field by field, with the oldest response still outstanding.
// ----------------------------------------------------------------------------
module job_queue_checker
    import spjq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req_payload,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_rsp i_rsp_payload,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_job        held_jobs [CAPACITY];
    int unsigned held_count;
    t_rsp        outstanding_rsps [$];
    int          fail_count;
    int          pending_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // Take out the job at pos and close the gap behind it
    function automatic t_job pull_job(input int unsigned pos);
        t_job taken;
        taken = held_jobs[pos];
        for (int unsigned k = pos; k + 1 < held_count; k++) begin
            held_jobs[k] = held_jobs[k + 1];
        end
        held_count--;
        return taken;
    endfunction

    // Apply one request to the held jobs and return the response it yields
    function automatic t_rsp apply_queue_op(input t_req cmd);
        t_rsp        rsp;
        t_job        taken;
        int unsigned pos;
        rsp = '0;
        rsp.status = ST_DONE;
        case (cmd.opcode)
            OP_INSERT: begin
                if (held_count >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    // new job goes behind every job of greater or equal rank
                    pos = 0;
                    while (pos < held_count && held_jobs[pos].rank >= cmd.job_rank) begin
                        pos++;
                    end
                    for (int unsigned k = held_count; k > pos; k--) begin
                        held_jobs[k] = held_jobs[k - 1];
                    end
                    held_jobs[pos].id   = cmd.job_id;
                    held_jobs[pos].rank = cmd.job_rank;
                    held_count++;
                end
            end
            OP_REMOVE_TOP: begin
                if (held_count == 0) begin
                    rsp.status = ST_MISS;
                end else begin
                    taken = pull_job(0);
                    rsp.removed_id   = taken.id;
                    rsp.removed_rank = taken.rank;
                end
            end
            OP_DELETE_ID: begin
                // first match in queue order
                pos = 0;
                while (pos < held_count && held_jobs[pos].id != cmd.job_id) begin
                    pos++;
                end
                if (pos < held_count) begin
                    taken = pull_job(pos);
                    rsp.removed_id   = taken.id;
                    rsp.removed_rank = taken.rank;
                end else begin
                    rsp.status = ST_MISS;
                end
            end
            default: begin
                // unused opcode leaves the queue alone
            end
        endcase
        rsp.entry_count = CNT_OUT_W'(held_count);
        return rsp;
    endfunction

    function automatic void report_mismatch(input string field,
                                            input logic signed [31:0] want,
                                            input logic signed [31:0] got);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        fail_count++;
    endfunction

    initial begin
        fail_count    = 0;
        pending_count = 0;
        held_count    = 0;
    end

    // Check responses first, then record the response of a new request
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            held_count = 0;
            outstanding_rsps.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (outstanding_rsps.size() == 0) begin
                    $display("%0t ns: response with none outstanding, got %p",
                             $time, i_rsp_payload);
                    fail_count++;
                end else begin
                    want = outstanding_rsps.pop_front();
                    if (i_rsp_payload.status !== want.status)
                        report_mismatch("status", want.status, i_rsp_payload.status);
                    if (i_rsp_payload.removed_id !== want.removed_id)
                        report_mismatch("removed_id", want.removed_id,
                                        i_rsp_payload.removed_id);
                    if (i_rsp_payload.removed_rank !== want.removed_rank)
                        report_mismatch("removed_rank", want.removed_rank,
                                        i_rsp_payload.removed_rank);
                    if (i_rsp_payload.entry_count !== want.entry_count)
                        report_mismatch("entry_count", want.entry_count,
                                        i_rsp_payload.entry_count);
                end
            end
            if (i_req_valid && i_req_ready) begin
                outstanding_rsps.push_back(apply_queue_op(i_req_payload));
            end
        end
        pending_count = outstanding_rsps.size();
    end

endmodule

@@ bench/sorted_priority_job_queue_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_job_queue_tb
// Drives the job queue with a directed opening (empty queue, extreme ids and
// ranks, ties, duplicate ids, a full queue) and then phases of random
// requests that in turn fill, mix and drain the queue. Both channels idle at
// random; the checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module sorted_priority_job_queue_tb
    import spjq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              CAPACITY     = 16;
    localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
    localparam int              PHASES       = 12;
    localparam int              PHASE_ITEMS  = 40;
    localparam int              HOLD_CYCLES  = 300;
    localparam int              IDLE_LIMIT   = 2000;
    localparam int              SETTLE_TICKS = 10;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   burst_left;
    logic hold_request;

    spjq_stream_if #(.T_PAYLOAD(t_req)) req_ch ();
    spjq_stream_if #(.T_PAYLOAD(t_rsp)) rsp_ch ();

    sorted_priority_job_queue #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    job_queue_checker #(
        .CAPACITY (CAPACITY)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_ch.valid),
        .i_req_ready   (req_ch.ready),
        .i_req_payload (req_ch.payload),
        .i_rsp_valid   (rsp_ch.valid),
        .i_rsp_ready   (rsp_ch.ready),
        .i_rsp_payload (rsp_ch.payload),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one request, hold it until taken, then maybe idle between bursts
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [ID_W-1:0] id,
                                input logic signed [RANK_W-1:0] rank);
        int gap;
        req_ch.valid   <= 1'b1;
        req_ch.payload <= '{opcode: op, job_id: id, job_rank: rank};
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(10, 30);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Stop offering requests until every response has come back
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // One random request; fill_pct steers the mix toward inserts or removals
    task automatic send_random(input int fill_pct);
        int                       roll;
        logic [OP_W-1:0]          op;
        logic [ID_W-1:0]          id;
        logic signed [RANK_W-1:0] rank;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            op = OP_UNUSED;
        else if (roll < fill_pct)
            op = OP_INSERT;
        else if (roll < fill_pct + (100 - fill_pct) / 2)
            op = OP_REMOVE_TOP;
        else
            op = OP_DELETE_ID;
        // small id pool so deletes hit and duplicates occur
        if ($urandom_range(0, 3) == 0)
            id = ID_W'($urandom);
        else
            id = ID_W'($urandom_range(0, 23));
        case ($urandom_range(0, 3))
            0: rank = RANK_W'($urandom);
            1: rank = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: rank = RANK_W'($urandom_range(0, 6)) - 16'sd3;
        endcase
        send_request(op, id, rank);
    endtask

    // Response side: stall patterns that change now and then, plus one long hold
    initial begin : rsp_stall
        int mode;
        int mode_left;
        bit hold_done;
        mode      = 0;
        mode_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= ((mode_left % 8) < 5);
            endcase
        end
    end

    // End the run when neither channel moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int fill_pct;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        hold_request   = 1'b0;
        burst_left     = 0;
        i_rst_n        = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue, unused opcode
        send_request(OP_REMOVE_TOP, 16'h0000, 16'sd0);
        send_request(OP_DELETE_ID, 16'h1234, 16'sd0);
        send_request(OP_UNUSED, 16'hFFFF, 16'sh7FFF);
        // extreme ids and ranks
        send_request(OP_INSERT, 16'hFFFF, 16'sh7FFF);
        send_request(OP_INSERT, 16'h0000, 16'sh8000);
        send_request(OP_INSERT, 16'h8000, 16'sh8000);
        send_request(OP_INSERT, 16'h7FFF, 16'sh7FFF);
        // ties and duplicate ids up to a full queue
        for (int k = 0; k < CAPACITY - 4; k++) begin
            send_request(OP_INSERT, ID_W'(k % 4 + 3), RANK_W'(k % 3) - 16'sd1);
        end
        send_request(OP_INSERT, 16'hABCD, 16'sd0);
        send_request(OP_DELETE_ID, 16'h0004, 16'sd0);
        send_request(OP_DELETE_ID, 16'h5555, 16'sd0);
        send_request(OP_REMOVE_TOP, 16'h0000, 16'sd0);
        drain_responses();

        // random phases: fill, mixed, drain
        for (int p = 0; p < PHASES; p++) begin
            fill_pct = (p % 3 == 0) ? 85 : (p % 3 == 1) ? 50 : 20;
            if (p == 3)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random(fill_pct);
            end
            if (p == 6)
                drain_responses();
        end

        drain_responses();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/spjq_pkg.sv
rtl/spjq_stream_if.sv
rtl/spjq_cell.sv
rtl/sorted_priority_job_queue.sv
bench/job_queue_checker.sv
bench/sorted_priority_job_queue_tb.sv
